// ===== src/pgve_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pgve_pkg;

    localparam int POSITION_BITS = 32;
    localparam int GROUP_BITS    = 7;
    localparam int NUM_GROUPS    = (POSITION_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int SER_BITS      = NUM_GROUPS * GROUP_BITS;
    localparam int CNT_BITS      = $clog2(NUM_GROUPS + 1);

    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic                     first_of_list;
    } pos_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic       order_error;
    } code_item_t;

    // control from the sequencer to the gap datapath
    typedef struct packed {
        logic load;
        logic step;
        logic raw;
        logic commit;
        logic shift_out;
    } gap_ctl_t;

    typedef struct packed {
        logic borrow;
        logic nonzero;
    } gap_sts_t;

endpackage

`default_nettype wire

// ===== src/posting_gap_vbyte_encoder.sv =====
// Variable-byte gap encoder for posting lists. Each accepted position (first_of_list
// marks a list start, coded raw) is turned into its gap from the previous position and
// sent as 7-bit groups, most significant first, bit 7 set on the final byte. The gap is
// formed by a digit-serial subtractor, one 7-bit digit per cycle, then a check state
// tests ordering and the output walks all five group slots at one per cycle while the
// output is not stalled, skipping leading zero groups. A position not above the previous
// one gives one error transfer instead, unless it starts a list. A result held on a
// stalled output does not block the next input.
`timescale 1ns / 1ps
`default_nettype none

module posting_gap_vbyte_encoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pos_valid,
    output logic                      pos_stall,
    input  wire pgve_pkg::pos_item_t  pos_item,
    output logic                      code_valid,
    input  wire logic                 code_stall,
    output pgve_pkg::code_item_t      code_item
);
    import pgve_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SUB   = 4'b0010,
        ST_CHECK = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic                  err_reg, err_next;
    logic                  first_reg, first_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  started_reg, started_next;
    logic                  code_valid_reg, code_valid_next;
    code_item_t            code_item_reg, code_item_next;

    gap_ctl_t              ctl;
    gap_sts_t              sts;
    logic [GROUP_BITS-1:0] top_group;
    logic                  slot_free;
    logic                  last_group;

    pgve_gap_unit u_gap (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .position  (pos_item.position),
        .sts       (sts),
        .top_group (top_group)
    );

    assign slot_free  = !code_valid_reg || !code_stall;
    assign last_group = (cnt_reg == CNT_BITS'(1));
    assign pos_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        err_next        = err_reg;
        first_next      = first_reg;
        cnt_next        = cnt_reg;
        started_next    = started_reg;
        code_valid_next = code_valid_reg && code_stall;
        code_item_next  = code_item_reg;
        ctl             = '0;
        ctl.raw         = first_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pos_valid)
                begin
                    ctl.load   = 1'b1;
                    first_next = pos_item.first_of_list;
                    cnt_next   = '0;
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(NUM_GROUPS - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // borrow out means position below previous, no nonzero digit means equal
                err_next     = !first_reg && (sts.borrow || !sts.nonzero);
                ctl.commit   = first_reg || (!sts.borrow && sts.nonzero);
                cnt_next     = CNT_BITS'(NUM_GROUPS);
                started_next = 1'b0;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    if (err_reg)
                    begin
                        code_valid_next            = 1'b1;
                        code_item_next.code_byte   = '0;
                        code_item_next.last_byte   = 1'b1;
                        code_item_next.order_error = 1'b1;
                        state_next                 = ST_IDLE;
                    end
                    else
                    begin
                        ctl.shift_out = 1'b1;
                        cnt_next      = cnt_reg - CNT_BITS'(1);
                        // leading zero groups are dropped, the final group always goes
                        if (started_reg || (top_group != '0) || last_group)
                        begin
                            started_next               = 1'b1;
                            code_valid_next            = 1'b1;
                            code_item_next.code_byte   = {last_group, top_group};
                            code_item_next.last_byte   = last_group;
                            code_item_next.order_error = 1'b0;
                        end
                        if (last_group)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            err_reg        <= 1'b0;
            first_reg      <= 1'b0;
            cnt_reg        <= '0;
            started_reg    <= 1'b0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            err_reg        <= err_next;
            first_reg      <= first_next;
            cnt_reg        <= cnt_next;
            started_reg    <= started_next;
            code_valid_reg <= code_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_item_reg <= code_item_next;
    end

    assign code_valid = code_valid_reg;
    assign code_item  = code_item_reg;

endmodule

`default_nettype wire

// ===== src/pgve_gap_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgve_gap_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pgve_pkg::gap_ctl_t                ctl,
    input  wire logic [pgve_pkg::POSITION_BITS-1:0] position,
    output pgve_pkg::gap_sts_t                     sts,
    output logic [pgve_pkg::GROUP_BITS-1:0]        top_group
);
    import pgve_pkg::*;

    logic [SER_BITS-1:0]   pos_sh_reg, pos_sh_next;
    logic [SER_BITS-1:0]   prev_sh_reg, prev_sh_next;
    logic [SER_BITS-1:0]   diff_reg, diff_next;
    logic                  borrow_reg, borrow_next;
    logic                  nz_reg, nz_next;
    logic [GROUP_BITS-1:0] sub_b;
    logic [GROUP_BITS:0]   digit;

    // one 7-bit digit of pos - prev per step, lsb digit first
    always_comb
    begin
        sub_b = ctl.raw ? '0 : prev_sh_reg[GROUP_BITS-1:0];
        digit = {1'b0, pos_sh_reg[GROUP_BITS-1:0]} - {1'b0, sub_b}
                - {{GROUP_BITS{1'b0}}, borrow_reg};
    end

    always_comb
    begin
        pos_sh_next  = pos_sh_reg;
        prev_sh_next = prev_sh_reg;
        diff_next    = diff_reg;
        borrow_next  = borrow_reg;
        nz_next      = nz_reg;
        if (ctl.load)
        begin
            pos_sh_next = {{(SER_BITS - POSITION_BITS){1'b0}}, position};
            borrow_next = 1'b0;
            nz_next     = 1'b0;
        end
        else if (ctl.step)
        begin
            // operands rotate so they are back in place after the last digit
            pos_sh_next  = {pos_sh_reg[GROUP_BITS-1:0], pos_sh_reg[SER_BITS-1:GROUP_BITS]};
            prev_sh_next = {prev_sh_reg[GROUP_BITS-1:0],
                            prev_sh_reg[SER_BITS-1:GROUP_BITS]};
            diff_next    = {digit[GROUP_BITS-1:0], diff_reg[SER_BITS-1:GROUP_BITS]};
            borrow_next  = digit[GROUP_BITS];
            nz_next      = nz_reg | (digit[GROUP_BITS-1:0] != '0);
        end
        else if (ctl.shift_out)
        begin
            diff_next = {diff_reg[SER_BITS-GROUP_BITS-1:0], {GROUP_BITS{1'b0}}};
        end
        if (ctl.commit)
        begin
            prev_sh_next = pos_sh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sh_reg <= '0;
            borrow_reg  <= 1'b0;
            nz_reg      <= 1'b0;
        end
        else
        begin
            prev_sh_reg <= prev_sh_next;
            borrow_reg  <= borrow_next;
            nz_reg      <= nz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_sh_reg <= pos_sh_next;
        diff_reg   <= diff_next;
    end

    assign sts.borrow  = borrow_reg;
    assign sts.nonzero = nz_reg;
    assign top_group   = diff_reg[SER_BITS-1:SER_BITS-GROUP_BITS];

endmodule

`default_nettype wire

// ===== src/pgve_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pgve_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 pos_valid,
    input wire logic                 pos_stall,
    input wire pgve_pkg::pos_item_t  pos_item,
    input wire logic                 code_valid,
    input wire logic                 code_stall,
    input wire pgve_pkg::code_item_t code_item
);
    import pgve_pkg::*;

    // an error transfer is a lone zero byte that closes its item
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_item.order_error |->
            code_item.last_byte && (code_item.code_byte == 8'h00))
        else $error("order error transfer is malformed");

    // the stop bit marks exactly the last byte of a coded value
    a_stop_bit: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_item.order_error |->
            (code_item.code_byte[7] == code_item.last_byte))
        else $error("stop bit and last_byte disagree");

    // one position at a time: an input transfer is followed by stall
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && !pos_stall |=> pos_stall)
        else $error("input taken while an item is in work");

    // a stalled input keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && pos_stall |=> pos_valid && $stable(pos_item))
        else $error("stalled input changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> code_valid && $stable(code_item))
        else $error("stalled output changed");

endmodule

bind posting_gap_vbyte_encoder pgve_checker u_pgve_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pos_valid  (pos_valid),
    .pos_stall  (pos_stall),
    .pos_item   (pos_item),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item)
);

`default_nettype wire

// ===== bench/posting_gap_vbyte_encoder_tb.sv =====
`timescale 1ns / 1ps

module posting_gap_vbyte_encoder_tb;

    import pgve_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 30;
    localparam int RANDOM_ITEMS = 155;

    typedef struct {
        pos_item_t item;
        bit        wait_drain;
    } pos_request_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       pos_valid;
    logic       pos_stall;
    pos_item_t  pos_item;
    logic       code_valid;
    logic       code_stall;
    code_item_t code_item;

    pos_request_t pending_positions[$];
    code_item_t   expected_codes[$];

    logic [POSITION_BITS-1:0] last_position;
    logic [POSITION_BITS-1:0] gen_prev;
    int error_count = 0;
    int accepted_positions = 0;
    int queued_positions = 0;
    int drain_index = 110;
    int cycle_count = 0;
    int send_wait;
    int recv_wait;
    bit send_burst;
    bit recv_burst;

    posting_gap_vbyte_encoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pos_valid  (pos_valid),
        .pos_stall  (pos_stall),
        .pos_item   (pos_item),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_item  (code_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR: %s got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    // expected code bytes for one accepted position
    task automatic predict_codes(input pos_item_t it);
        logic [POSITION_BITS-1:0] value;
        code_item_t c;
        int n;
        if (!it.first_of_list && it.position <= last_position)
        begin
            c.code_byte   = 8'h00;
            c.last_byte   = 1'b1;
            c.order_error = 1'b1;
            expected_codes.insert(expected_codes.size(), c);
            return;
        end
        value = it.first_of_list ? it.position : it.position - last_position;
        last_position = it.position;
        n = 1;
        while (n < NUM_GROUPS && (value >> (GROUP_BITS * n)) != 0)
            n++;
        for (int k = n - 1; k >= 0; k--)
        begin
            c.code_byte   = {k == 0, 7'(value >> (GROUP_BITS * k))};
            c.last_byte   = (k == 0);
            c.order_error = 1'b0;
            expected_codes.insert(expected_codes.size(), c);
        end
    endtask

    function automatic logic [31:0] random_span();
        int w;
        w = $urandom_range(32, 0);
        if (w == 32)
            return $urandom;
        return $urandom & ((32'd1 << w) - 32'd1);
    endfunction

    task automatic add_pos(input logic [31:0] pos, input bit first);
        pos_request_t r;
        r.item.position      = pos;
        r.item.first_of_list = first;
        r.wait_drain         = (pending_positions.size() == drain_index);
        pending_positions.insert(pending_positions.size(), r);
        queued_positions++;
        if (first || pos > gen_prev)
            gen_prev = pos;
    endtask

    // next position of the current list, in order unless the list already holds the top value
    task automatic add_next();
        logic [31:0] room;
        logic [31:0] gap;
        room = 32'hFFFF_FFFF - gen_prev;
        if (room == 0)
        begin
            add_pos($urandom_range(gen_prev, 0), 1'b0);
            return;
        end
        gap = random_span();
        if (gap == 0)
            gap = 1;
        if (gap > room)
            gap = $urandom_range(room, 1);
        add_pos(gen_prev + gap, 1'b0);
    endtask

    // input side: one transfer at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid  <= 1'b0;
            pos_item   <= '0;
            send_wait  = 0;
            send_burst = 1'b0;
            last_position = '0;
        end
        else
        begin
            if (pos_valid && !pos_stall)
            begin
                predict_codes(pos_item);
                accepted_positions++;
                if ($urandom_range(31, 0) == 0)
                    send_burst = !send_burst;
                send_wait = send_burst ? 0 : $urandom_range(7, 0);
            end
            if (!(pos_valid && pos_stall))
            begin
                if (send_wait != 0)
                begin
                    send_wait--;
                    pos_valid <= 1'b0;
                end
                else if (pending_positions.size() != 0 &&
                         (!pending_positions[0].wait_drain || expected_codes.size() == 0))
                begin
                    pos_item  <= pending_positions[0].item;
                    pos_valid <= 1'b1;
                    void'(pending_positions.pop_front());
                end
                else
                begin
                    pos_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each transfer, then stall for a random while
    always @(posedge clk or negedge rst_n)
    begin
        code_item_t want;
        if (!rst_n)
        begin
            code_stall <= 1'b1;
            recv_wait  = 0;
            recv_burst = 1'b0;
        end
        else
        begin
            if (code_valid && !code_stall)
            begin
                if (expected_codes.size() == 0)
                begin
                    report_mismatch("unexpected code transfer, byte", code_item.code_byte, 0);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (code_item.code_byte !== want.code_byte)
                        report_mismatch("code_byte", code_item.code_byte, want.code_byte);
                    if (code_item.last_byte !== want.last_byte)
                        report_mismatch("last_byte", code_item.last_byte, want.last_byte);
                    if (code_item.order_error !== want.order_error)
                        report_mismatch("order_error", code_item.order_error, want.order_error);
                end
                if ($urandom_range(31, 0) == 0)
                    recv_burst = !recv_burst;
                recv_wait = recv_burst ? 0 : $urandom_range(7, 0);
            end
            if (recv_wait != 0)
            begin
                recv_wait--;
                code_stall <= 1'b1;
            end
            else
            begin
                code_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int random_items;
        int run;
        int pick;
        gen_prev = '0;
        random_items = 0;

        // no list started yet: compared against a previous position of zero
        add_pos(32'd0, 1'b0);
        add_pos(32'd5, 1'b0);
        add_pos(32'd0, 1'b1);
        add_pos(32'd0, 1'b0);
        add_pos(32'd127, 1'b1);
        add_pos(32'd128, 1'b0);
        add_pos(32'd256, 1'b0);
        add_pos(32'd16383, 1'b1);
        add_pos(32'd16384, 1'b1);
        add_pos(32'd0, 1'b1);
        add_pos(32'd2097151, 1'b0);
        add_pos(32'd4194303, 1'b0);
        add_pos(32'h0FFF_FFFF, 1'b1);
        add_pos(32'h1000_0000, 1'b1);
        add_pos(32'hFFFF_FFFF, 1'b1);
        add_pos(32'hFFFF_FFFF, 1'b0);
        add_pos(32'd1, 1'b0);
        add_pos(32'd1, 1'b1);
        add_pos(32'hFFFF_FFFF, 1'b0);
        add_pos(32'h8000_0000, 1'b1);
        add_pos(32'h7FFF_FFFF, 1'b1);
        add_pos(32'h5555_5555, 1'b1);
        add_pos(32'hAAAA_AAAA, 1'b0);

        // mostly well-formed lists, with order errors and stray items mixed in
        while (random_items < RANDOM_ITEMS)
        begin
            add_pos(random_span(), 1'b1);
            random_items++;
            run = $urandom_range(8, 1);
            for (int j = 0; j < run; j++)
            begin
                pick = $urandom_range(9, 0);
                if (pick == 0)
                    add_pos($urandom_range(gen_prev, 0), 1'b0);
                else if (pick == 1)
                    add_pos($urandom, 1'($urandom_range(1, 0)));
                else
                    add_next();
                random_items++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_positions < queued_positions)
            @(posedge clk);
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
src/pgve_pkg.sv
src/pgve_gap_unit.sv
src/posting_gap_vbyte_encoder.sv
src/pgve_checker.sv
bench/posting_gap_vbyte_encoder_tb.sv
